// ===== design/itt_pkg.sv =====
// Shared constants, codes and types for the idle-timeout table.
package itt_pkg;

    localparam int ENTRIES = 64;
    localparam int IDX_W   = $clog2(ENTRIES);
    localparam int CNT_W   = IDX_W + 1;
    localparam int TIME_W  = 32;
    localparam int SLOT_W  = 6;
    localparam int OP_W    = 3;
    localparam int STAT_W  = 2;

    localparam logic [TIME_W-1:0] TIMEOUT_RESET = TIME_W'(60);

    localparam logic [OP_W-1:0] OP_INSERT = 3'd0;
    localparam logic [OP_W-1:0] OP_TOUCH  = 3'd1;
    localparam logic [OP_W-1:0] OP_REMOVE = 3'd2;
    localparam logic [OP_W-1:0] OP_EXPIRE = 3'd3;
    localparam logic [OP_W-1:0] OP_FLUSH  = 3'd4;

    localparam logic [STAT_W-1:0] ST_OK         = 2'd0;
    localparam logic [STAT_W-1:0] ST_IN_USE     = 2'd1;
    localparam logic [STAT_W-1:0] ST_NOT_IN_USE = 2'd2;

    typedef struct packed {
        logic              en;
        logic [IDX_W-1:0]  addr;
        logic [TIME_W-1:0] data;
    } ram_wr_t;

    typedef enum logic [2:0] {
        SEQ_IDLE = 3'b001,
        SEQ_SCAN = 3'b010,
        SEQ_DONE = 3'b100
    } seq_state_t;

endpackage

// ===== design/idle_timeout_table.sv =====
// Idle-timeout table: valid bits, timestamp memory and the scan sequencer.
//
// A table of ENTRIES slots, each with a valid bit and a last-used timestamp.
// Insert, touch and remove each return one registered result, valid in the
// cycle after the request is taken. Expire and flush walk every slot through
// the timestamp memory's single read port and the shared age comparator, one
// slot per cycle while the output is not stalled reporting dropped slots.
// Drops come out in ascending slot order, the final one with tlast; a scan
// that drops nothing returns one result for slot 0 with tuser low. The input
// side is ready only between transactions, once the output register is free.
// The user must write the timeout through cfg_we/cfg_wdata only while the
// block is idle; the block does not enforce this. It resets to 60 seconds.
module idle_timeout_table (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [31:0] cfg_wdata,   // timeout_seconds
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,     // [5:0] slot, [37:6] now_seconds, [39:38] zero
    input  logic [2:0]  s_tuser,     // opcode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,     // [5:0] result_slot, [7:6] status
    output logic        m_tuser,     // dropped
    output logic        m_tlast
);
    import itt_pkg::*;

    seq_state_t          state_reg, state_next;
    logic [TIME_W-1:0]   timeout_reg;
    logic [ENTRIES-1:0]  valid_reg, valid_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic                flush_reg, flush_next;

    logic                s1_valid_reg, s1_valid_next;
    logic                s1_live_reg, s1_live_next;
    logic [IDX_W-1:0]    s1_idx_reg, s1_idx_next;

    logic                pend_valid_reg, pend_valid_next;
    logic [IDX_W-1:0]    pend_slot_reg, pend_slot_next;

    logic                m_valid_reg, m_valid_next;
    logic [SLOT_W-1:0]   m_slot_reg, m_slot_next;
    logic                m_drop_reg, m_drop_next;
    logic [STAT_W-1:0]   m_status_reg, m_status_next;
    logic                m_last_reg, m_last_next;

    logic [OP_W-1:0]     op_in;
    logic [SLOT_W-1:0]   slot_in;
    logic [TIME_W-1:0]   now_in;
    logic [IDX_W-1:0]    idx_in;
    logic                in_range;
    logic                accept;
    logic                out_free;
    logic                thr_load;
    logic                expired;
    logic                s2_hit;
    logic                stall;
    ram_wr_t             ram_wr;
    logic                rd_en;
    logic [TIME_W-1:0]   rd_data;

    assign op_in    = s_tuser;
    assign slot_in  = s_tdata[SLOT_W-1:0];
    assign now_in   = s_tdata[SLOT_W+TIME_W-1:SLOT_W];
    assign idx_in   = slot_in[IDX_W-1:0];
    assign in_range = {1'b0, slot_in} < (SLOT_W+1)'(ENTRIES);

    assign out_free = !m_valid_reg || m_tready;
    assign s_tready = (state_reg == SEQ_IDLE) && out_free;
    assign accept   = s_tvalid && s_tready;
    assign thr_load = accept && (op_in == OP_EXPIRE || op_in == OP_FLUSH);

    // stage 2: the stamp held in the read port's register is tested now
    assign s2_hit = s1_valid_reg && s1_live_reg && (flush_reg || expired);
    // a new drop must push the held one out; wait if the output is busy
    assign stall  = s2_hit && pend_valid_reg && !out_free;

    itt_time_ram u_ram (
        .clk     (clk),
        .wr      (ram_wr),
        .rd_en   (rd_en),
        .rd_addr (cnt_reg[IDX_W-1:0]),
        .rd_data (rd_data)
    );

    itt_age_cmp u_cmp (
        .clk             (clk),
        .rst_n           (rst_n),
        .load            (thr_load),
        .now_seconds     (now_in),
        .timeout_seconds (timeout_reg),
        .stamp           (rd_data),
        .expired         (expired)
    );

    always_comb
    begin
        state_next      = state_reg;
        valid_next      = valid_reg;
        cnt_next        = cnt_reg;
        flush_next      = flush_reg;
        s1_valid_next   = s1_valid_reg;
        s1_live_next    = s1_live_reg;
        s1_idx_next     = s1_idx_reg;
        pend_valid_next = pend_valid_reg;
        pend_slot_next  = pend_slot_reg;
        m_valid_next    = m_valid_reg && !m_tready;
        m_slot_next     = m_slot_reg;
        m_drop_next     = m_drop_reg;
        m_status_next   = m_status_reg;
        m_last_next     = m_last_reg;
        ram_wr.en       = 1'b0;
        ram_wr.addr     = idx_in;
        ram_wr.data     = now_in;
        rd_en           = 1'b0;

        case (state_reg)
            SEQ_IDLE:
            begin
                if (accept)
                begin
                    m_valid_next  = 1'b1;
                    m_slot_next   = slot_in;
                    m_drop_next   = 1'b0;
                    m_status_next = ST_OK;
                    m_last_next   = 1'b1;
                    case (op_in)
                        OP_INSERT:
                        begin
                            if (!in_range)
                            begin
                                m_status_next = ST_NOT_IN_USE;
                            end
                            else if (valid_reg[idx_in])
                            begin
                                m_status_next = ST_IN_USE;
                            end
                            else
                            begin
                                valid_next[idx_in] = 1'b1;
                                ram_wr.en          = 1'b1;
                            end
                        end
                        OP_TOUCH:
                        begin
                            if (!in_range || !valid_reg[idx_in])
                            begin
                                m_status_next = ST_NOT_IN_USE;
                            end
                            else
                            begin
                                ram_wr.en = 1'b1;
                            end
                        end
                        OP_REMOVE:
                        begin
                            if (!in_range || !valid_reg[idx_in])
                            begin
                                m_status_next = ST_NOT_IN_USE;
                            end
                            else
                            begin
                                valid_next[idx_in] = 1'b0;
                            end
                        end
                        OP_EXPIRE, OP_FLUSH:
                        begin
                            m_valid_next    = 1'b0;
                            flush_next      = (op_in == OP_FLUSH);
                            cnt_next        = '0;
                            s1_valid_next   = 1'b0;
                            pend_valid_next = 1'b0;
                            state_next      = SEQ_SCAN;
                        end
                        default:
                        begin
                            // unused opcode: echo the slot, table untouched
                        end
                    endcase
                end
            end
            SEQ_SCAN:
            begin
                if (!stall)
                begin
                    if (s2_hit)
                    begin
                        valid_next[s1_idx_reg] = 1'b0;
                        if (pend_valid_reg)
                        begin
                            m_valid_next  = 1'b1;
                            m_slot_next   = SLOT_W'(pend_slot_reg);
                            m_drop_next   = 1'b1;
                            m_status_next = ST_OK;
                            m_last_next   = 1'b0;
                        end
                        pend_valid_next = 1'b1;
                        pend_slot_next  = s1_idx_reg;
                    end
                    if (cnt_reg < CNT_W'(ENTRIES))
                    begin
                        rd_en         = 1'b1;
                        s1_valid_next = 1'b1;
                        s1_idx_next   = cnt_reg[IDX_W-1:0];
                        s1_live_next  = valid_reg[cnt_reg[IDX_W-1:0]];
                        cnt_next      = cnt_reg + 1'b1;
                    end
                    else
                    begin
                        s1_valid_next = 1'b0;
                        if (!s1_valid_reg)
                        begin
                            state_next = SEQ_DONE;
                        end
                    end
                end
            end
            SEQ_DONE:
            begin
                // the held drop is the last one; with none, report empty scan
                if (out_free)
                begin
                    m_valid_next    = 1'b1;
                    m_slot_next     = pend_valid_reg ? SLOT_W'(pend_slot_reg) : '0;
                    m_drop_next     = pend_valid_reg;
                    m_status_next   = ST_OK;
                    m_last_next     = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = SEQ_IDLE;
                end
            end
            default:
            begin
                state_next = SEQ_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= SEQ_IDLE;
            timeout_reg    <= TIMEOUT_RESET;
            valid_reg      <= '0;
            cnt_reg        <= '0;
            flush_reg      <= 1'b0;
            s1_valid_reg   <= 1'b0;
            pend_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            if (cfg_we)
            begin
                timeout_reg <= cfg_wdata;
            end
            valid_reg      <= valid_next;
            cnt_reg        <= cnt_next;
            flush_reg      <= flush_next;
            s1_valid_reg   <= s1_valid_next;
            pend_valid_reg <= pend_valid_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_live_reg   <= s1_live_next;
        s1_idx_reg    <= s1_idx_next;
        pend_slot_reg <= pend_slot_next;
        m_slot_reg    <= m_slot_next;
        m_drop_reg    <= m_drop_next;
        m_status_reg  <= m_status_next;
        m_last_reg    <= m_last_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {m_status_reg, m_slot_reg};
    assign m_tuser  = m_drop_reg;
    assign m_tlast  = m_last_reg;

endmodule

// ===== design/itt_time_ram.sv =====
// Timestamp memory: one write port, one registered read port.
module itt_time_ram (
    input  logic                         clk,
    input  itt_pkg::ram_wr_t             wr,
    input  logic                         rd_en,
    input  logic [itt_pkg::IDX_W-1:0]    rd_addr,
    output logic [itt_pkg::TIME_W-1:0]   rd_data
);
    import itt_pkg::*;

    logic [TIME_W-1:0] mem [ENTRIES];

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== design/itt_age_cmp.sv =====
// Age compare unit: holds the saturated expiry threshold and tests stamps against it.
module itt_age_cmp (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        load,
    input  logic [itt_pkg::TIME_W-1:0]  now_seconds,
    input  logic [itt_pkg::TIME_W-1:0]  timeout_seconds,
    input  logic [itt_pkg::TIME_W-1:0]  stamp,
    output logic                        expired
);
    import itt_pkg::*;

    logic [TIME_W:0]   diff;
    logic [TIME_W-1:0] thr_reg;
    logic [TIME_W-1:0] thr_next;

    // borrow out of the subtract means now < timeout: clamp to zero
    assign diff     = {1'b0, now_seconds} - {1'b0, timeout_seconds};
    assign thr_next = diff[TIME_W] ? '0 : diff[TIME_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= '0;
        end
        else if (load)
        begin
            thr_reg <= thr_next;
        end
    end

    assign expired = stamp < thr_reg;

endmodule
